// File: src/led_matrix_bcm_scanner_defines.svh
// Assertion macros shared by the scanner modules.
`ifndef LED_MATRIX_BCM_SCANNER_DEFINES_SVH
`define LED_MATRIX_BCM_SCANNER_DEFINES_SVH
// Antecedent implies consequent in the same cycle.
`define LMBS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define LMBS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: src/lmbs_pkg.sv
// Types, constants and helpers shared by the LED matrix scanner modules.
package lmbs_pkg;
   localparam int PANEL_ROWS_DEF = 32;
   localparam int PANEL_COLS_DEF = 32;
   localparam int PLANES_DEF = 7;
   localparam int QUEUE_DEPTH = 2;
   localparam int PERIOD_W = 22;
   localparam logic [15:0] PERIOD_BASE_RESET = 16'd240;

   typedef enum logic [1:0] {
      REG_DRAW_RED = 2'd0,
      REG_DRAW_GREEN = 2'd1,
      REG_DRAW_BLUE = 2'd2,
      REG_PERIOD_BASE = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_TICK = 3'd0,
      OP_PIXEL = 3'd1,
      OP_ROW_LINE = 3'd2,
      OP_COL_LINE = 3'd3,
      OP_FILL = 3'd4,
      OP_CLEAR = 3'd5,
      OP_MASK_ROW = 3'd6,
      OP_NONE = 3'd7
   } opcode_type;

   typedef struct packed {
      opcode_type op;
      logic [4:0] row;
      logic [4:0] col;
      logic [5:0] len;
      logic [31:0] mask;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_LINE,
      ST_SWEEP,
      ST_TICK
   } back_state_type;

   function automatic logic [3:0] row_scramble(input logic [3:0] r);
      logic [3:0] s;
      case (r)
         4'd2: s = 4'd4;
         4'd3: s = 4'd5;
         4'd4: s = 4'd2;
         4'd5: s = 4'd3;
         4'd10: s = 4'd12;
         4'd11: s = 4'd13;
         4'd12: s = 4'd10;
         4'd13: s = 4'd11;
         default: s = r;
      endcase
      return s;
   endfunction
endpackage

// File: src/lmbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lmbs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: src/lmbs_front.sv
// Command intake: accepts request beats, drops no-op commands, queues the rest.
`include "led_matrix_bcm_scanner_defines.svh"
module lmbs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_opcode,
   input  logic [4:0]        req_row,
   input  logic [4:0]        req_col,
   input  logic [5:0]        req_run_length,
   input  logic [31:0]       req_row_mask,
   input  logic              init_busy,
   input  logic              pop,
   output logic              q_valid,
   output lmbs_pkg::cmd_type q_head
);
   localparam int DEPTH = lmbs_pkg::QUEUE_DEPTH;

   lmbs_pkg::cmd_type q_ff [DEPTH];
   logic [$clog2(DEPTH)-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [$clog2(DEPTH):0] count_ff, count_in;
   lmbs_pkg::cmd_type cmd;
   logic keep, push, accept;

   always_comb begin
      cmd.op = lmbs_pkg::opcode_type'(req_opcode);
      cmd.row = req_row;
      cmd.col = req_col;
      cmd.len = req_run_length;
      cmd.mask = req_row_mask;
      case (cmd.op)
         lmbs_pkg::OP_ROW_LINE, lmbs_pkg::OP_COL_LINE: keep = req_run_length != 6'd0;
         lmbs_pkg::OP_MASK_ROW: keep = req_row_mask != 32'd0;
         lmbs_pkg::OP_NONE: keep = 1'b0;
         default: keep = 1'b1;
      endcase
   end

   assign req_stall = init_busy || (count_ff == ($clog2(DEPTH)+1)'(DEPTH));
   assign accept = req_valid && !req_stall;
   assign push = accept && keep;
   assign q_valid = count_ff != '0;
   assign q_head = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + ($clog2(DEPTH)+1)'(push) - ($clog2(DEPTH)+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

   `LMBS_ASSERT_IMP(a_queue_bound, clock, reset, 1'b1, count_ff <= ($clog2(DEPTH)+1)'(DEPTH))
   `LMBS_ASSERT_NEXT(a_pop_needs_entry, clock, reset, pop, $past(count_ff) != '0)
endmodule

// File: src/lmbs_back.sv
// Command executor: draws into the frame store and shifts out bit planes.
`include "led_matrix_bcm_scanner_defines.svh"
module lmbs_back #(
   parameter int PANEL_ROWS = lmbs_pkg::PANEL_ROWS_DEF,
   parameter int PANEL_COLS = lmbs_pkg::PANEL_COLS_DEF,
   parameter int PLANES = lmbs_pkg::PLANES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  lmbs_pkg::cmd_type q_head,
   output logic              pop,
   output logic              init_busy,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_write_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [4:0]        rsp_column,
   output logic              rsp_upper_red,
   output logic              rsp_upper_green,
   output logic              rsp_upper_blue,
   output logic              rsp_lower_red,
   output logic              rsp_lower_green,
   output logic              rsp_lower_blue,
   output logic              rsp_latch_last,
   output logic [3:0]        rsp_row_address,
   output logic [21:0]       rsp_plane_period
);
   localparam int HALF = PANEL_ROWS / 2;
   localparam int CW = $clog2(PANEL_COLS);
   localparam int DEPTH = HALF * PANEL_COLS;
   localparam int AW = $clog2(DEPTH);
   localparam int RLW = $clog2(HALF);

   lmbs_pkg::back_state_type st_ff, st_in;
   logic [7:0] red_ff, green_ff, blue_ff;
   logic [15:0] base_ff;
   logic [RLW-1:0] scan_row_ff, scan_row_in;
   logic [2:0] plane_ff, plane_in;
   logic [6:0] cur_row_ff, cur_row_in;
   logic [7:0] cur_col_ff, cur_col_in;
   logic [5:0] left_ff, left_in;
   lmbs_pkg::opcode_type mode_ff, mode_in;
   logic [31:0] mask_ff, mask_in;
   logic fill_ff, fill_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic [CW:0] tcol_ff, tcol_in;
   logic pend_ff, pend_in;
   logic [CW-1:0] pend_col_ff, pend_col_in;
   logic issue, load, in_range, line_we, lower;
   logic [6:0] local_row;
   logic [15:0] line_addr_w, rd_addr_w;
   logic up_we, lo_we;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [23:0] wr_data, color, dout_up, dout_lo;
   logic [7:0] ur, ug, ub, lr, lg, lb;
   logic last_col;

   logic rsp_valid_ff, rsp_valid_in;
   logic [4:0] rsp_column_ff;
   logic [5:0] rsp_bits_ff;
   logic rsp_last_ff;
   logic [3:0] rsp_row_address_ff;
   logic [21:0] rsp_period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff <= '0;
         green_ff <= '0;
         blue_ff <= '0;
         base_ff <= lmbs_pkg::PERIOD_BASE_RESET;
      end else if (csr_write_enable) begin
         case (lmbs_pkg::csr_index_type'(csr_index))
            lmbs_pkg::REG_DRAW_RED: red_ff <= csr_write_data[7:0];
            lmbs_pkg::REG_DRAW_GREEN: green_ff <= csr_write_data[7:0];
            lmbs_pkg::REG_DRAW_BLUE: blue_ff <= csr_write_data[7:0];
            lmbs_pkg::REG_PERIOD_BASE: base_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign color = {red_ff, green_ff, blue_ff};
   assign in_range = (cur_row_ff < 7'(PANEL_ROWS)) && (cur_col_ff < 8'(PANEL_COLS));
   assign lower = cur_row_ff >= 7'(HALF);
   assign local_row = lower ? cur_row_ff - 7'(HALF) : cur_row_ff;
   assign line_addr_w = 16'(local_row) * 16'(PANEL_COLS) + 16'(cur_col_ff);
   assign line_we = (st_ff == lmbs_pkg::ST_LINE) && in_range &&
      ((mode_ff != lmbs_pkg::OP_MASK_ROW) || mask_ff[cur_col_ff[4:0]]);
   assign rd_addr_w = 16'(scan_row_ff) * 16'(PANEL_COLS) + 16'(tcol_ff);
   assign rd_addr = rd_addr_w[AW-1:0];

   always_comb begin
      up_we = 1'b0;
      lo_we = 1'b0;
      wr_addr = line_addr_w[AW-1:0];
      wr_data = color;
      case (st_ff)
         lmbs_pkg::ST_INIT: begin
            up_we = 1'b1;
            lo_we = 1'b1;
            wr_addr = sweep_ff;
            wr_data = '0;
         end
         lmbs_pkg::ST_SWEEP: begin
            up_we = 1'b1;
            lo_we = 1'b1;
            wr_addr = sweep_ff;
            wr_data = fill_ff ? color : '0;
         end
         lmbs_pkg::ST_LINE: begin
            up_we = line_we && !lower;
            lo_we = line_we && lower;
         end
         default: ;
      endcase
   end

   lmbs_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_ram_up (
      .clock(clock), .wr_en(up_we), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_en(issue), .rd_addr(rd_addr), .rd_data(dout_up)
   );

   lmbs_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_ram_lo (
      .clock(clock), .wr_en(lo_we), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_en(issue), .rd_addr(rd_addr), .rd_data(dout_lo)
   );

   assign load = pend_ff && (!rsp_valid_ff || !rsp_stall);
   assign issue = (st_ff == lmbs_pkg::ST_TICK) && (tcol_ff < (CW+1)'(PANEL_COLS)) &&
      (!pend_ff || load);
   assign init_busy = st_ff == lmbs_pkg::ST_INIT;

   always_comb begin
      st_in = st_ff;
      pop = 1'b0;
      scan_row_in = scan_row_ff;
      plane_in = plane_ff;
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      left_in = left_ff;
      mode_in = mode_ff;
      mask_in = mask_ff;
      fill_in = fill_ff;
      sweep_in = sweep_ff;
      tcol_in = tcol_ff;
      pend_in = issue ? 1'b1 : (load ? 1'b0 : pend_ff);
      pend_col_in = issue ? tcol_ff[CW-1:0] : pend_col_ff;
      case (st_ff)
         lmbs_pkg::ST_INIT, lmbs_pkg::ST_SWEEP: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == AW'(DEPTH - 1)) begin
               st_in = lmbs_pkg::ST_IDLE;
               sweep_in = '0;
            end
         end
         lmbs_pkg::ST_IDLE: begin
            if (q_valid) begin
               pop = 1'b1;
               mode_in = q_head.op;
               mask_in = q_head.mask;
               cur_row_in = 7'(q_head.row);
               cur_col_in = 8'(q_head.col);
               left_in = q_head.len;
               case (q_head.op)
                  lmbs_pkg::OP_TICK: begin
                     st_in = lmbs_pkg::ST_TICK;
                     tcol_in = '0;
                  end
                  lmbs_pkg::OP_FILL, lmbs_pkg::OP_CLEAR: begin
                     st_in = lmbs_pkg::ST_SWEEP;
                     fill_in = q_head.op == lmbs_pkg::OP_FILL;
                     sweep_in = '0;
                  end
                  lmbs_pkg::OP_PIXEL: begin
                     st_in = lmbs_pkg::ST_LINE;
                     left_in = 6'd1;
                  end
                  lmbs_pkg::OP_MASK_ROW: begin
                     st_in = lmbs_pkg::ST_LINE;
                     cur_col_in = '0;
                     left_in = 6'd32;
                  end
                  default: st_in = lmbs_pkg::ST_LINE;
               endcase
            end
         end
         lmbs_pkg::ST_LINE: begin
            left_in = left_ff - 1'b1;
            if (mode_ff == lmbs_pkg::OP_COL_LINE) begin
               cur_row_in = cur_row_ff + 1'b1;
            end else begin
               cur_col_in = cur_col_ff + 1'b1;
            end
            if (left_ff == 6'd1) begin
               st_in = lmbs_pkg::ST_IDLE;
            end
         end
         lmbs_pkg::ST_TICK: begin
            if (issue) begin
               tcol_in = tcol_ff + 1'b1;
            end
            if ((tcol_ff == (CW+1)'(PANEL_COLS)) && !pend_ff) begin
               st_in = lmbs_pkg::ST_IDLE;
               if (plane_ff >= 3'(PLANES - 1)) begin
                  plane_in = '0;
                  scan_row_in = (scan_row_ff == RLW'(HALF - 1)) ? '0 : scan_row_ff + 1'b1;
               end else begin
                  plane_in = plane_ff + 1'b1;
               end
            end
         end
         default: st_in = lmbs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= lmbs_pkg::ST_INIT;
         sweep_ff <= '0;
         scan_row_ff <= '0;
         plane_ff <= '0;
         pend_ff <= 1'b0;
         tcol_ff <= '0;
      end else begin
         st_ff <= st_in;
         sweep_ff <= sweep_in;
         scan_row_ff <= scan_row_in;
         plane_ff <= plane_in;
         pend_ff <= pend_in;
         tcol_ff <= tcol_in;
      end
      cur_row_ff <= cur_row_in;
      cur_col_ff <= cur_col_in;
      left_ff <= left_in;
      mode_ff <= mode_in;
      mask_ff <= mask_in;
      fill_ff <= fill_in;
      pend_col_ff <= pend_col_in;
   end

   assign ur = dout_up[23:16];
   assign ug = dout_up[15:8];
   assign ub = dout_up[7:0];
   assign lr = dout_lo[23:16];
   assign lg = dout_lo[15:8];
   assign lb = dout_lo[7:0];
   assign last_col = pend_col_ff == CW'(PANEL_COLS - 1);
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         rsp_column_ff <= 5'(pend_col_ff);
         rsp_bits_ff <= {ur[plane_ff], ug[plane_ff], ub[plane_ff],
                         lr[plane_ff], lg[plane_ff], lb[plane_ff]};
         rsp_last_ff <= last_col;
         rsp_row_address_ff <= last_col ? lmbs_pkg::row_scramble(4'(scan_row_ff)) : 4'd0;
         rsp_period_ff <= last_col ? (22'(base_ff) << plane_ff) : 22'd0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_column = rsp_column_ff;
   assign rsp_upper_red = rsp_bits_ff[5];
   assign rsp_upper_green = rsp_bits_ff[4];
   assign rsp_upper_blue = rsp_bits_ff[3];
   assign rsp_lower_red = rsp_bits_ff[2];
   assign rsp_lower_green = rsp_bits_ff[1];
   assign rsp_lower_blue = rsp_bits_ff[0];
   assign rsp_latch_last = rsp_last_ff;
   assign rsp_row_address = rsp_row_address_ff;
   assign rsp_plane_period = rsp_period_ff;

   `LMBS_ASSERT_NEXT(a_pend_held, clock, reset, pend_ff && !load, pend_ff)
   `LMBS_ASSERT_IMP(a_last_col, clock, reset, rsp_valid_ff && rsp_last_ff, rsp_column_ff == 5'(PANEL_COLS - 1))
   `LMBS_ASSERT_IMP(a_init_quiet, clock, reset, st_ff == lmbs_pkg::ST_INIT, !pend_ff && !pop)
endmodule

// File: src/led_matrix_bcm_scanner.sv
// LED matrix scanner with binary coded modulation. After reset the block
// clears its frame store, PANEL_ROWS/2 * PANEL_COLS addresses (512 at the
// default size), one address of both panel halves a cycle, and takes no
// request beat until then. Accepted commands wait in a two-entry queue, and
// the back end pops each one in its idle state before it runs. A refresh
// tick then gives PANEL_COLS response beats, one per cycle when the response
// side does not stall, paced by the frame store read port. A pixel writes
// one address, a line walks its run length, a mask row walks all 32 columns,
// and a fill or clear sweeps the whole frame store. Zero-length lines, empty
// masks and the unused opcode are dropped on intake.
module led_matrix_bcm_scanner #(
   parameter int PANEL_ROWS = lmbs_pkg::PANEL_ROWS_DEF,
   parameter int PANEL_COLS = lmbs_pkg::PANEL_COLS_DEF,
   parameter int PLANES = lmbs_pkg::PLANES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [4:0]  req_row,
   input  logic [4:0]  req_col,
   input  logic [5:0]  req_run_length,
   input  logic [31:0] req_row_mask,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_column,
   output logic        rsp_upper_red,
   output logic        rsp_upper_green,
   output logic        rsp_upper_blue,
   output logic        rsp_lower_red,
   output logic        rsp_lower_green,
   output logic        rsp_lower_blue,
   output logic        rsp_latch_last,
   output logic [3:0]  rsp_row_address,
   output logic [21:0] rsp_plane_period
);
   logic q_valid, pop, init_busy;
   lmbs_pkg::cmd_type q_head;

   lmbs_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_opcode(req_opcode), .req_row(req_row), .req_col(req_col),
      .req_run_length(req_run_length), .req_row_mask(req_row_mask),
      .init_busy(init_busy), .pop(pop), .q_valid(q_valid), .q_head(q_head)
   );

   lmbs_back #(.PANEL_ROWS(PANEL_ROWS), .PANEL_COLS(PANEL_COLS), .PLANES(PLANES)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_head(q_head), .pop(pop), .init_busy(init_busy),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_column(rsp_column),
      .rsp_upper_red(rsp_upper_red), .rsp_upper_green(rsp_upper_green),
      .rsp_upper_blue(rsp_upper_blue), .rsp_lower_red(rsp_lower_red),
      .rsp_lower_green(rsp_lower_green), .rsp_lower_blue(rsp_lower_blue),
      .rsp_latch_last(rsp_latch_last), .rsp_row_address(rsp_row_address),
      .rsp_plane_period(rsp_plane_period)
   );
endmodule

// File: sim/led_matrix_bcm_scanner_tb.sv
// Self-checking testbench for the LED matrix scanner: drawing commands and refresh ticks.
module led_matrix_bcm_scanner_tb;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 2000;

   typedef struct packed {
      logic [4:0]  column;
      logic [2:0]  upper_rgb;
      logic [2:0]  lower_rgb;
      logic        latch_last;
      logic [3:0]  row_address;
      logic [21:0] plane_period;
   } shift_beat_type;

   typedef struct packed {
      lmbs_pkg::opcode_type op;
      logic [4:0]  row;
      logic [4:0]  col;
      logic [5:0]  len;
      logic [31:0] mask;
   } command_type;

   localparam logic [3:0] ROW_DEMUX [16] = '{4'd0, 4'd1, 4'd4, 4'd5, 4'd2, 4'd3, 4'd6,
      4'd7, 4'd8, 4'd9, 4'd12, 4'd13, 4'd10, 4'd11, 4'd14, 4'd15};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_opcode = '0;
   logic [4:0] req_row = '0;
   logic [4:0] req_col = '0;
   logic [5:0] req_run_length = '0;
   logic [31:0] req_row_mask = '0;
   logic csr_write_enable = 1'b0;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_write_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [4:0] rsp_column;
   logic rsp_upper_red, rsp_upper_green, rsp_upper_blue;
   logic rsp_lower_red, rsp_lower_green, rsp_lower_blue;
   logic rsp_latch_last;
   logic [3:0] rsp_row_address;
   logic [21:0] rsp_plane_period;

   led_matrix_bcm_scanner dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   logic [7:0] frame_red [32][32];
   logic [7:0] frame_green [32][32];
   logic [7:0] frame_blue [32][32];
   logic [3:0] scan_row;
   logic [2:0] bit_plane;
   logic [7:0] color_red, color_green, color_blue;
   logic [15:0] period_base;

   command_type pending_cmds[$];
   shift_beat_type expected_beats[$];
   int failures = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int cycles = 0;
   command_type current_cmd;

   task automatic paint(input int r, input int c);
      if (r < 32 && c < 32) begin
         frame_red[r][c] = color_red;
         frame_green[r][c] = color_green;
         frame_blue[r][c] = color_blue;
      end
   endtask

   task automatic clear_frame();
      for (int r = 0; r < 32; r++)
         for (int c = 0; c < 32; c++) begin
            frame_red[r][c] = '0;
            frame_green[r][c] = '0;
            frame_blue[r][c] = '0;
         end
   endtask

   task automatic apply_command(input command_type cmd);
      shift_beat_type b;
      int up, lo;
      up = scan_row;
      lo = up + 16;
      case (cmd.op)
         lmbs_pkg::OP_TICK: begin
            for (int c = 0; c < 32; c++) begin
               b = '0;
               b.column = 5'(c);
               b.upper_rgb = {frame_red[up][c][bit_plane], frame_green[up][c][bit_plane],
                  frame_blue[up][c][bit_plane]};
               b.lower_rgb = {frame_red[lo][c][bit_plane], frame_green[lo][c][bit_plane],
                  frame_blue[lo][c][bit_plane]};
               if (c == 31) begin
                  b.latch_last = 1'b1;
                  b.row_address = ROW_DEMUX[up];
                  b.plane_period = 22'(period_base) << bit_plane;
               end
               expected_beats.push_back(b);
            end
            if (bit_plane == 3'd6) begin
               bit_plane = '0;
               scan_row = scan_row + 4'd1;
            end else begin
               bit_plane = bit_plane + 3'd1;
            end
         end
         lmbs_pkg::OP_PIXEL: paint(cmd.row, cmd.col);
         lmbs_pkg::OP_ROW_LINE: for (int i = 0; i < cmd.len; i++) paint(cmd.row, cmd.col + i);
         lmbs_pkg::OP_COL_LINE: for (int i = 0; i < cmd.len; i++) paint(cmd.row + i, cmd.col);
         lmbs_pkg::OP_FILL: for (int r = 0; r < 32; r++) for (int c = 0; c < 32; c++) paint(r, c);
         lmbs_pkg::OP_CLEAR: clear_frame();
         lmbs_pkg::OP_MASK_ROW: for (int c = 0; c < 32; c++) if (cmd.mask[c]) paint(cmd.row, c);
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) apply_command(current_cmd);
         if (!req_valid || !req_stall) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               current_cmd = pending_cmds.pop_front();
               req_valid <= 1'b1;
               req_opcode <= current_cmd.op;
               req_row <= current_cmd.row;
               req_col <= current_cmd.col;
               req_run_length <= current_cmd.len;
               req_row_mask <= current_cmd.mask;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      shift_beat_type got, want;
      got = {rsp_column, rsp_upper_red, rsp_upper_green, rsp_upper_blue, rsp_lower_red,
         rsp_lower_green, rsp_lower_blue, rsp_latch_last, rsp_row_address, rsp_plane_period};
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected beat %h", $time, got);
            failures++;
         end else begin
            want = expected_beats.pop_front();
            if (got != want) begin
               $display("%0t: mismatch col %0d rgb %b/%b last %b addr %0d period %0d",
                  $time, want.column, want.upper_rgb, want.lower_rgb, want.latch_last,
                  want.row_address, want.plane_period);
               $display("%0t:   actual col %0d rgb %b/%b last %b addr %0d period %0d",
                  $time, got.column, got.upper_rgb, got.lower_rgb, got.latch_last,
                  got.row_address, got.plane_period);
               failures++;
            end
         end
      end
      if (hold_left == 0 && holds_served < hold_requests) begin
         holds_served++;
         hold_left = 3000;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic write_reg(input lmbs_pkg::csr_index_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      case (idx)
         lmbs_pkg::REG_DRAW_RED: color_red = value[7:0];
         lmbs_pkg::REG_DRAW_GREEN: color_green = value[7:0];
         lmbs_pkg::REG_DRAW_BLUE: color_blue = value[7:0];
         default: period_base = value;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pending_cmds.size() > 0 || req_valid || expected_beats.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_colors(input logic [15:0] r, input logic [15:0] g,
                             input logic [15:0] b, input logic [15:0] base);
      write_reg(lmbs_pkg::REG_DRAW_RED, r);
      write_reg(lmbs_pkg::REG_DRAW_GREEN, g);
      write_reg(lmbs_pkg::REG_DRAW_BLUE, b);
      write_reg(lmbs_pkg::REG_PERIOD_BASE, base);
   endtask

   task automatic push(input lmbs_pkg::opcode_type op, input int r, input int c,
                       input int len, input logic [31:0] mask);
      command_type cmd;
      cmd.op = op;
      cmd.row = 5'(r);
      cmd.col = 5'(c);
      cmd.len = 6'(len);
      cmd.mask = mask;
      pending_cmds.push_back(cmd);
   endtask

   task automatic push_random(input int count);
      int pick;
      lmbs_pkg::opcode_type op;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 35) op = lmbs_pkg::OP_TICK;
         else if (pick < 50) op = lmbs_pkg::OP_PIXEL;
         else if (pick < 62) op = lmbs_pkg::OP_ROW_LINE;
         else if (pick < 74) op = lmbs_pkg::OP_COL_LINE;
         else if (pick < 88) op = lmbs_pkg::OP_MASK_ROW;
         else if (pick < 90) op = lmbs_pkg::OP_FILL;
         else if (pick < 92) op = lmbs_pkg::OP_CLEAR;
         else if (pick < 94) op = lmbs_pkg::OP_NONE;
         else op = lmbs_pkg::OP_PIXEL;
         push(op, $urandom_range(31), $urandom_range(31), $urandom_range(63), $urandom());
      end
   endtask

   initial begin
      clear_frame();
      scan_row = '0;
      bit_plane = '0;
      color_red = '0;
      color_green = '0;
      color_blue = '0;
      period_base = 16'd240;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      set_colors(16'hFFFF, 16'h0000, 16'h00A5, 16'd0);
      push(lmbs_pkg::OP_TICK, 0, 0, 0, '0);
      push(lmbs_pkg::OP_PIXEL, 0, 0, 0, '0);
      push(lmbs_pkg::OP_PIXEL, 31, 31, 0, '0);
      push(lmbs_pkg::OP_ROW_LINE, 16, 30, 32, '0);
      push(lmbs_pkg::OP_COL_LINE, 20, 1, 63, '0);
      push(lmbs_pkg::OP_ROW_LINE, 0, 5, 0, '0);
      push(lmbs_pkg::OP_COL_LINE, 0, 5, 0, '0);
      push(lmbs_pkg::OP_MASK_ROW, 17, 0, 0, 32'hFFFF_FFFF);
      push(lmbs_pkg::OP_MASK_ROW, 1, 0, 0, 32'h0);
      push(lmbs_pkg::OP_NONE, 31, 31, 63, 32'hFFFF_FFFF);
      for (int i = 0; i < 3; i++) push(lmbs_pkg::OP_TICK, 0, 0, 0, '0);
      push(lmbs_pkg::OP_FILL, 0, 0, 0, '0);
      push(lmbs_pkg::OP_TICK, 0, 0, 0, '0);
      push(lmbs_pkg::OP_CLEAR, 0, 0, 0, '0);
      push(lmbs_pkg::OP_TICK, 0, 0, 0, '0);
      wait_idle();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase % 3)
            0: begin send_idle_pct = 35; recv_idle_pct = 50; end
            1: begin send_idle_pct = 50; recv_idle_pct = 35; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         case (phase)
            0: set_colors(16'h0000, 16'hFFFF, 16'h00FF, 16'hFFFF);
            1: set_colors(16'h00FF, 16'h0000, 16'h0000, 16'd1);
            2: set_colors(16'h0055, 16'h00AA, 16'h0033, 16'd240);
            3: set_colors(16'($urandom()), 16'($urandom()), 16'($urandom()),
                          16'($urandom()));
            4: set_colors(16'h00FF, 16'h00FF, 16'h00FF, 16'h8001);
            default: set_colors(16'h00C3, 16'h003C, 16'h0000, 16'd0);
         endcase
         if (phase == 2) hold_requests++;
         push_random(60);
         wait_idle();
      end

      if (expected_beats.size() != 0) failures++;
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
